// ===== src/bce_pkg.sv =====
// Shared types and constants for the cross-shaped binary erosion block.
// No dependencies; used by binary_cross_erosion, bce_queue_cell, bce_out_stage and the bench.
package bce_pkg;

    localparam int CFG_W     = 11;   // configuration word width
    localparam int COUNT_W   = 21;   // white pixel count, kept modulo 2^21
    localparam int CFG_RESET = 950;  // reset value of both image edges
    localparam int MIN_EDGE  = 3;    // smallest image edge in use
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 24;

    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_DRAIN = 1'b1
    } cmd_t;

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_idx_t;

    // One pending pixel: its own value and the pixel one row above it
    typedef struct packed {
        logic pix;
        logic up;
    } entry_t;

    // Broadcast to every queue cell
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } queue_ctl_t;

    typedef struct packed {
        logic                eroded;
        logic                last;
        logic [COUNT_W-1:0]  count;
    } result_t;

endpackage

// ===== src/binary_cross_erosion.sv =====
// Streaming binary erosion with a plus-shaped 3x3 element. Pixels come in
// raster order, one word each (tuser low = pixel, tuser high = drain). A white
// pixel stays white only if its left, right, upper and lower neighbours are
// all white; anything outside the image counts as black. A result leaves one
// image row after its own pixel, on the word that brings the pixel below it;
// until a full row is pending, pixel words give no result. Each drain word
// pushes out one pending result (lower neighbour taken as black), or nothing
// when none is pending. The result of the final pixel of an image has tlast
// set and carries the image's white pixel count (modulo 2^21). A
// configuration write restarts the stream and keeps no pending results.
// Rate: one word per clock while s_tready is high; the word's result is registered and
// appears on m_ in the cycle after acceptance when m_ is free. s_tready drops
// while both slots of the output stage hold results, and while a
// configuration write is offered (the write goes first). The row history is
// a chain of MAX_WIDTH delay cells and the pending pixels a chain of
// MAX_WIDTH queue cells; both move at most one step per word, so no memory port
// limits throughput.
// Uses bce_pkg, bce_delay_cell, bce_queue_cell, bce_out_stage.
module binary_cross_erosion #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input words
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bce_pkg::IN_DATA_W-1:0]     s_tdata,  // [0] pixel_white
    input  logic                              s_tuser,  // [0] command
    // results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bce_pkg::OUT_DATA_W-1:0]    m_tdata,  // [0] eroded_white, [21:1] white_count
    output logic                              m_tlast,  // last_pixel
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_index,
    input  logic [bce_pkg::CFG_W-1:0]         cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);        // column
    localparam int PW = $clog2(MAX_WIDTH + 1);    // width, pending count
    localparam int RW = $clog2(MAX_HEIGHT);       // row
    localparam int HW = $clog2(MAX_HEIGHT + 1);   // height
    localparam int NW = bce_pkg::COUNT_W;

    localparam logic [PW-1:0] WIDTH_RST =
        PW'((bce_pkg::CFG_RESET > MAX_WIDTH) ? MAX_WIDTH : bce_pkg::CFG_RESET);
    localparam logic [HW-1:0] HEIGHT_RST =
        HW'((bce_pkg::CFG_RESET > MAX_HEIGHT) ? MAX_HEIGHT : bce_pkg::CFG_RESET);

    // ---- state ----
    logic [PW-1:0] width_reg,       width_next;
    logic [HW-1:0] height_reg,      height_next;
    logic [CW-1:0] in_col_reg,      in_col_next;
    logic [RW-1:0] in_row_reg,      in_row_next;
    logic [CW-1:0] out_col_reg,     out_col_next;
    logic [RW-1:0] out_row_reg,     out_row_next;
    logic [PW-1:0] pend_reg,        pend_next;
    logic          prev_center_reg, prev_center_next;
    logic [NW-1:0] white_reg,       white_next;
    logic [NW-1:0] latched_reg,     latched_next;

    // ---- handshakes ----
    logic cfg_acc, accept, is_drain, pix_acc, drain_acc, pix;
    logic stage_ready;
    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid & cfg_ready;
    // a configuration write takes the cycle; the input word waits for it
    assign s_tready  = stage_ready & ~cfg_valid;
    assign accept    = s_tvalid & s_tready;
    assign is_drain  = (bce_pkg::cmd_t'(s_tuser) == bce_pkg::CMD_DRAIN);
    assign pix_acc   = accept & ~is_drain & ~cfg_acc;
    assign drain_acc = accept & is_drain & ~cfg_acc;
    assign pix       = s_tdata[0];

    // ---- saturated configuration values ----
    logic [31:0]   cfg_wide;
    logic [PW-1:0] sat_width;
    logic [HW-1:0] sat_height;
    assign cfg_wide   = 32'(cfg_data);
    assign sat_width  = (cfg_wide < 32'(bce_pkg::MIN_EDGE)) ? PW'(bce_pkg::MIN_EDGE) :
                        (cfg_wide > 32'(MAX_WIDTH))         ? PW'(MAX_WIDTH) :
                                                              PW'(cfg_wide);
    assign sat_height = (cfg_wide < 32'(bce_pkg::MIN_EDGE)) ? HW'(bce_pkg::MIN_EDGE) :
                        (cfg_wide > 32'(MAX_HEIGHT))        ? HW'(MAX_HEIGHT) :
                                                              HW'(cfg_wide);

    logic [CW-1:0] width_last;
    logic [RW-1:0] height_last;
    assign width_last  = CW'(width_reg - 1'b1);
    assign height_last = RW'(height_reg - 1'b1);

    // ---- cell chains ----
    // d_pix: row delay line; cell 0 holds the pixel one row before the next input
    // q_*:   pending pixels in stream order, head (next result) at cell 0
    logic [MAX_WIDTH:0]  d_pix;
    logic [MAX_WIDTH:0]  q_valid;
    bce_pkg::entry_t     q_entry [0:MAX_WIDTH];
    bce_pkg::entry_t     new_entry;
    bce_pkg::queue_ctl_t q_ctl;
    logic                emit;

    assign d_pix[MAX_WIDTH]   = 1'b0;
    assign q_valid[MAX_WIDTH] = 1'b0;
    assign q_entry[MAX_WIDTH] = '0;

    assign new_entry.pix = pix;
    assign new_entry.up  = d_pix[0];

    assign q_ctl.push  = pix_acc;
    assign q_ctl.pop   = emit;
    assign q_ctl.clear = cfg_acc;

    for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_cell
        logic prev_valid;
        if (i == 0) begin : g_head
            assign prev_valid = 1'b1;
        end else begin : g_body
            assign prev_valid = q_valid[i-1];
        end

        bce_delay_cell #(
            .INDEX (i),
            .CW    (CW)
        ) u_delay (
            .aclk     (aclk),
            .shift    (pix_acc),
            .tail_idx (width_last),
            .new_pix  (pix),
            .next_pix (d_pix[i+1]),
            .pix      (d_pix[i])
        );

        bce_queue_cell u_queue (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (q_ctl),
            .new_entry  (new_entry),
            .prev_valid (prev_valid),
            .next_valid (q_valid[i+1]),
            .next_entry (q_entry[i+1]),
            .valid      (q_valid[i]),
            .entry      (q_entry[i])
        );
    end

    // ---- neighbourhood of the head pixel ----
    logic full, has_pend, right_ok;
    logic out_first_row, out_last_row, out_col_first, out_col_last;
    logic center, up_n, left_n, right_n, down_n, last;
    logic frame_end;
    logic [NW-1:0] white_inc;

    assign full     = (pend_reg == width_reg);
    assign has_pend = (pend_reg != '0);
    assign emit     = (pix_acc & full) | (drain_acc & has_pend);
    // a drain sees its right neighbour only if that pixel has arrived
    assign right_ok = is_drain ? (pend_reg >= PW'(2)) : 1'b1;

    assign out_first_row = (out_row_reg == '0);
    assign out_last_row  = (out_row_reg == height_last);
    assign out_col_first = (out_col_reg == '0);
    assign out_col_last  = (out_col_reg == width_last);

    assign center  = q_entry[0].pix;
    assign up_n    = ~out_first_row & q_entry[0].up;
    assign left_n  = ~out_col_first & prev_center_reg;
    assign right_n = right_ok & ~out_col_last & q_entry[1].pix;
    assign down_n  = ~is_drain & ~out_last_row & pix;
    assign last    = out_last_row & out_col_last;

    assign frame_end = (in_col_reg == width_last) && (in_row_reg == height_last);
    assign white_inc = white_reg + NW'(pix);

    always_comb begin
        width_next       = width_reg;
        height_next      = height_reg;
        in_col_next      = in_col_reg;
        in_row_next      = in_row_reg;
        out_col_next     = out_col_reg;
        out_row_next     = out_row_reg;
        pend_next        = pend_reg;
        prev_center_next = prev_center_reg;
        white_next       = white_reg;
        latched_next     = latched_reg;
        if (cfg_acc) begin
            case (bce_pkg::reg_idx_t'(cfg_index))
                bce_pkg::REG_IMAGE_WIDTH:  width_next  = sat_width;
                bce_pkg::REG_IMAGE_HEIGHT: height_next = sat_height;
                default: ;
            endcase
            // restart; line contents are kept
            in_col_next      = '0;
            in_row_next      = '0;
            out_col_next     = '0;
            out_row_next     = '0;
            pend_next        = '0;
            prev_center_next = 1'b0;
            white_next       = '0;
            latched_next     = '0;
        end else begin
            if (pix_acc) begin
                white_next = white_inc;
                if (frame_end) begin
                    latched_next = white_inc;
                    white_next   = '0;
                end
                if (in_col_reg == width_last) begin
                    in_col_next = '0;
                    in_row_next = (in_row_reg == height_last) ? '0 : in_row_reg + 1'b1;
                end else begin
                    in_col_next = in_col_reg + 1'b1;
                end
                if (!full) begin
                    pend_next = pend_reg + 1'b1;
                end
            end
            if (drain_acc && has_pend) begin
                pend_next = pend_reg - 1'b1;
            end
            if (emit) begin
                prev_center_next = center;
                if (out_col_last) begin
                    out_col_next = '0;
                    out_row_next = out_last_row ? '0 : out_row_reg + 1'b1;
                end else begin
                    out_col_next = out_col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg       <= WIDTH_RST;
            height_reg      <= HEIGHT_RST;
            in_col_reg      <= '0;
            in_row_reg      <= '0;
            out_col_reg     <= '0;
            out_row_reg     <= '0;
            pend_reg        <= '0;
            prev_center_reg <= 1'b0;
            white_reg       <= '0;
            latched_reg     <= '0;
        end else begin
            width_reg       <= width_next;
            height_reg      <= height_next;
            in_col_reg      <= in_col_next;
            in_row_reg      <= in_row_next;
            out_col_reg     <= out_col_next;
            out_row_reg     <= out_row_next;
            pend_reg        <= pend_next;
            prev_center_reg <= prev_center_next;
            white_reg       <= white_next;
            latched_reg     <= latched_next;
        end
    end

    // ---- result and output stage ----
    bce_pkg::result_t res, m_res;
    assign res.eroded = center & up_n & left_n & right_n & down_n;
    assign res.last   = last;
    assign res.count  = last ? latched_next : '0;

    bce_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (emit),
        .in_ready   (stage_ready),
        .in_result  (res),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (m_res)
    );

    assign m_tdata = {{(bce_pkg::OUT_DATA_W - NW - 1){1'b0}}, m_res.count, m_res.eroded};
    assign m_tlast = m_res.last;

    // ---- assertions ----
    a_pend_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg <= width_reg)
        else $error("pending count exceeds row width");

    a_queue_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(q_valid) == 32'(pend_reg))
        else $error("queue occupancy disagrees with pending count");

    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(in_col_reg) < 32'(width_reg)) && (32'(out_col_reg) < 32'(width_reg)))
        else $error("column position outside the row");

    a_row_align: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> (in_col_reg == out_col_reg))
        else $error("full row pending but input and output columns differ");

endmodule

// ===== src/bce_delay_cell.sv =====
// One cell of the row delay line: holds one pixel, shifts towards cell 0.
// The cell at the last column of the row loads the incoming pixel instead.
// Depends on nothing.
module bce_delay_cell #(
    parameter int INDEX = 0,
    parameter int CW    = 10
) (
    input  logic          aclk,
    input  logic          shift,
    input  logic [CW-1:0] tail_idx,
    input  logic          new_pix,
    input  logic          next_pix,
    output logic          pix
);

    localparam logic [CW-1:0] MY_IDX = CW'(INDEX);

    logic pix_reg;

    always_ff @(posedge aclk) begin
        if (shift) begin
            pix_reg <= (tail_idx == MY_IDX) ? new_pix : next_pix;
        end
    end

    assign pix = pix_reg;

endmodule

// ===== src/bce_queue_cell.sv =====
// One cell of the pending-pixel queue: shift-register FIFO, head at cell 0.
// Uses bce_pkg (entry_t, queue_ctl_t).
module bce_queue_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  bce_pkg::queue_ctl_t ctl,
    input  bce_pkg::entry_t     new_entry,
    input  logic                prev_valid,
    input  logic                next_valid,
    input  bce_pkg::entry_t     next_entry,
    output logic                valid,
    output bce_pkg::entry_t     entry
);

    logic            valid_reg, valid_next;
    bce_pkg::entry_t entry_reg, entry_next;

    always_comb begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (ctl.clear) begin
            valid_next = 1'b0;
        end else if (ctl.pop && ctl.push) begin
            // shift up; the tail cell takes the new word
            if (next_valid) begin
                entry_next = next_entry;
            end else if (valid_reg) begin
                entry_next = new_entry;
            end
        end else if (ctl.pop) begin
            valid_next = next_valid;
            entry_next = next_entry;
        end else if (ctl.push) begin
            if (!valid_reg && prev_valid) begin
                valid_next = 1'b1;
                entry_next = new_entry;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign valid = valid_reg;
    assign entry = entry_reg;

endmodule

// ===== src/bce_out_stage.sv =====
// Output register with a skid slot; ready towards the input is registered.
// Uses bce_pkg (result_t).
module bce_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  bce_pkg::result_t in_result,
    output logic             out_valid,
    input  logic             out_ready,
    output bce_pkg::result_t out_result
);

    logic             main_valid_reg, main_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    bce_pkg::result_t main_reg, main_next;
    bce_pkg::result_t skid_reg, skid_next;
    logic             taken;

    assign taken = main_valid_reg & out_ready;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg) begin
            if (taken) begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (!main_valid_reg || taken) begin
            main_valid_next = in_valid;
            if (in_valid) begin
                main_next = in_result;
            end
        end else if (in_valid) begin
            skid_valid_next = 1'b1;
            skid_next       = in_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign in_ready   = ~skid_valid_reg;
    assign out_valid  = main_valid_reg;
    assign out_result = main_reg;

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for binary_cross_erosion: a directed table, one full-width line,
// then random small images with drain words, checked against an in-bench erosion predictor.
// Depends on bce_pkg and the RTL under src.
module tb;

    localparam int MAX_W         = 1024;
    localparam int MAX_H         = 1024;
    localparam int SETTLE_CYCLES = 8;     // result is registered in the output stage, behind its word
    localparam int STALL_LIMIT   = 5000;
    localparam int RANDOM_WORDS  = 550;

    typedef enum logic [1:0] {
        BY_MODEL,
        NO_WORD,
        FIXED_WORD
    } check_t;

    typedef struct {
        bce_pkg::cmd_t    cmd;
        logic             pix;
        check_t           chk;
        bce_pkg::result_t word;
    } stim_row_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [bce_pkg::IN_DATA_W-1:0]  s_tdata   = '0;
    logic                           s_tuser   = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [bce_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                           m_tlast;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic                           cfg_index = 1'b0;
    logic [bce_pkg::CFG_W-1:0]      cfg_data  = '0;

    always #1 aclk = ~aclk;

    binary_cross_erosion #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state
    logic [bce_pkg::CFG_W-1:0] width_reg  = bce_pkg::CFG_W'(bce_pkg::CFG_RESET);
    logic [bce_pkg::CFG_W-1:0] height_reg = bce_pkg::CFG_W'(bce_pkg::CFG_RESET);
    bit               line_now   [MAX_W];
    bit               line_above [MAX_W];
    int unsigned      in_col, in_row, out_idx, out_col, pending;
    int unsigned      white_run, white_latched;
    bit               prev_centre;

    bce_pkg::result_t eroded_q [$];
    bce_pkg::result_t head_word;
    stim_row_t        dir_rows [$];
    int unsigned mismatches   = 0;
    int unsigned words_sent   = 0;
    int unsigned quiet_cycles = 0;
    bit          steady       = 1'b0;

    function automatic int unsigned clamp_edge(logic [bce_pkg::CFG_W-1:0] v, int unsigned top);
        if (v < bce_pkg::MIN_EDGE) return bce_pkg::MIN_EDGE;
        if (v > top) return top;
        return v;
    endfunction

    function automatic void restart_stream();
        in_col        = 0;
        in_row        = 0;
        out_idx       = 0;
        out_col       = 0;
        pending       = 0;
        prev_centre   = 1'b0;
        white_run     = 0;
        white_latched = 0;
    endfunction

    // Erodes the oldest pending pixel; lower neighbour and whether the right one has arrived supplied by the caller
    function automatic bce_pkg::result_t erode_pixel(bit down, bit right_ok);
        int unsigned      w, h, c;
        bit               centre, up, left, right, last;
        bce_pkg::result_t r;
        w      = clamp_edge(width_reg, MAX_W);
        h      = clamp_edge(height_reg, MAX_H);
        c      = out_col % w;
        centre = line_now[c];
        up     = (out_idx >= w) ? line_above[c] : 1'b0;
        left   = (c > 0) ? prev_centre : 1'b0;
        right  = (right_ok && c + 1 < w) ? line_now[c + 1] : 1'b0;
        last   = (out_idx == w * h - 1);
        r.eroded = centre & left & right & up & down;
        r.last   = last;
        r.count  = last ? bce_pkg::COUNT_W'(white_latched) : '0;
        prev_centre = centre;
        out_col     = (c + 1 < w) ? c + 1 : 0;
        out_idx     = last ? 0 : out_idx + 1;
        return r;
    endfunction

    function automatic bit predict_erosion(bce_pkg::cmd_t cmd, logic pix,
                                           output bce_pkg::result_t r);
        int unsigned w, h, c;
        bit          got;
        w   = clamp_edge(width_reg, MAX_W);
        h   = clamp_edge(height_reg, MAX_H);
        r   = '0;
        got = 1'b0;
        if (cmd == bce_pkg::CMD_DRAIN) begin
            if (pending == 0) return 1'b0;
            r = erode_pixel(1'b0, pending >= 2);
            pending--;
            return 1'b1;
        end
        c = in_col % w;
        if (pix) white_run++;
        if (c == w - 1 && in_row >= h - 1) begin
            white_latched = white_run;
            white_run     = 0;
        end
        if (pending >= w) begin
            // bottom row of an image always sees black below
            r   = erode_pixel((out_idx >= (h - 1) * w) ? 1'b0 : pix, 1'b1);
            got = 1'b1;
        end else begin
            pending++;
        end
        line_above[c] = line_now[c];
        line_now[c]   = pix;
        if (c + 1 < w) begin
            in_col = c + 1;
        end else begin
            in_col = 0;
            in_row = (in_row + 1 < h) ? in_row + 1 : 0;
        end
        return got;
    endfunction

    task automatic send_word(bce_pkg::cmd_t cmd, logic pix, check_t chk = BY_MODEL,
                             bce_pkg::result_t fixed = '0);
        bce_pkg::result_t r;
        bit               got;
        while (!steady && $urandom_range(99) < 8) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= bce_pkg::IN_DATA_W'(pix);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        got = predict_erosion(cmd, pix, r);
        if (got || cmd == bce_pkg::CMD_PIXEL) words_sent++;
        case (chk)
            BY_MODEL:   if (got) eroded_q.push_back(r);
            FIXED_WORD: eroded_q.push_back(fixed);
            default: ;
        endcase
    endtask

    // Drop valid, wait for every expected word, then let the pipeline go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (eroded_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes both edges back to back, in random order; each write restarts the stream
    task automatic set_image(int unsigned w_val, int unsigned h_val);
        bce_pkg::reg_idx_t idx;
        int unsigned       v;
        bit                height_first;
        height_first = $urandom_range(1);
        for (int k = 0; k < 2; k++) begin
            idx = ((k == 0) ^ height_first) ? bce_pkg::REG_IMAGE_WIDTH
                                            : bce_pkg::REG_IMAGE_HEIGHT;
            v   = (idx == bce_pkg::REG_IMAGE_WIDTH) ? w_val : h_val;
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= bce_pkg::CFG_W'(v);
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            if (idx == bce_pkg::REG_IMAGE_WIDTH) width_reg = bce_pkg::CFG_W'(v);
            else height_reg = bce_pkg::CFG_W'(v);
            restart_stream();
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic add_row(bce_pkg::cmd_t cmd, logic pix, check_t chk, logic ero = 1'b0,
                           logic lst = 1'b0, int unsigned cnt = 0);
        stim_row_t row;
        row.cmd         = cmd;
        row.pix         = pix;
        row.chk         = chk;
        row.word.eroded = ero;
        row.word.last   = lst;
        row.word.count  = bce_pkg::COUNT_W'(cnt);
        dir_rows.push_back(row);
    endtask

    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 8);
    end

    // Result checker: every word against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (eroded_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: eroded=%0b last=%0b count=%0d",
                             m_tdata[0], m_tlast, m_tdata[bce_pkg::COUNT_W:1]);
            end else begin
                head_word = eroded_q.pop_front();
                if (m_tdata[0] !== head_word.eroded || m_tlast !== head_word.last ||
                    m_tdata[bce_pkg::COUNT_W:1] !== head_word.count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected eroded=%0b last=%0b count=%0d, %s%0b %s%0b %s%0d",
                                 head_word.eroded, head_word.last, head_word.count,
                                 "got eroded=", m_tdata[0], "last=", m_tlast,
                                 "count=", m_tdata[bce_pkg::COUNT_W:1]);
                end
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    initial begin
        int unsigned base, w_val, h_val, we, he, n, images, density;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        set_image(3, 3);

        // All-white 3x3: first row only fills the line, then only the centre survives
        for (int k = 0; k < 9; k++)
            add_row(bce_pkg::CMD_PIXEL, 1'b1, (k < 3) ? NO_WORD : FIXED_WORD, k == 7);
        // Next image straight behind: its first row pushes out the white image's last row
        add_row(bce_pkg::CMD_PIXEL, 1'b1, FIXED_WORD, 1'b0);
        add_row(bce_pkg::CMD_PIXEL, 1'b1, FIXED_WORD, 1'b0);
        add_row(bce_pkg::CMD_PIXEL, 1'b1, FIXED_WORD, 1'b0, 1'b1, 9);
        for (int k = 0; k < 6; k++)
            add_row(bce_pkg::CMD_PIXEL, k != 3, BY_MODEL);
        // Partial drain, a pixel behind it, then drain past the received pixels
        add_row(bce_pkg::CMD_DRAIN, 1'b0, BY_MODEL);
        add_row(bce_pkg::CMD_PIXEL, 1'b1, BY_MODEL);
        add_row(bce_pkg::CMD_DRAIN, 1'b1, BY_MODEL);
        add_row(bce_pkg::CMD_DRAIN, 1'b0, BY_MODEL);
        add_row(bce_pkg::CMD_DRAIN, 1'b1, BY_MODEL);
        add_row(bce_pkg::CMD_DRAIN, 1'b0, NO_WORD);
        foreach (dir_rows[i])
            send_word(dir_rows[i].cmd, dir_rows[i].pix, dir_rows[i].chk, dir_rows[i].word);
        settle();

        // Widest line, width saturated from all ones: fill it, then drain a few;
        // no stalls on either side
        steady = 1'b1;
        set_image(2047, 3);
        for (int i = 0; i < MAX_W + 6; i++)
            send_word(bce_pkg::CMD_PIXEL, $urandom_range(99) < 90);
        repeat (6) send_word(bce_pkg::CMD_DRAIN, 1'b0);
        settle();
        steady = 1'b0;

        base = words_sent;
        while (words_sent - base < RANDOM_WORDS) begin
            case ($urandom_range(7))
                0:       w_val = $urandom_range(2);
                1:       w_val = $urandom_range(9, 16);
                default: w_val = $urandom_range(3, 6);
            endcase
            h_val  = ($urandom_range(5) == 0) ? $urandom_range(2) : $urandom_range(3, 5);
            set_image(w_val, h_val);
            we     = clamp_edge(bce_pkg::CFG_W'(w_val), MAX_W);
            he     = clamp_edge(bce_pkg::CFG_W'(h_val), MAX_H);
            images = $urandom_range(1, 3);
            for (int img = 0; img < images; img++) begin
                case ($urandom_range(2))
                    0:       density = 50;
                    1:       density = 85;
                    default: density = 100;
                endcase
                n = we * he;
                // sometimes cut the last image short; the next write restarts anyway
                if (img == images - 1 && $urandom_range(3) == 0) n = $urandom_range(1, n - 1);
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(99) < 4)
                        send_word(bce_pkg::CMD_DRAIN, $urandom_range(1));
                    send_word(bce_pkg::CMD_PIXEL, $urandom_range(99) < density);
                end
                if ($urandom_range(1))
                    repeat ($urandom_range(we, we + 2))
                        send_word(bce_pkg::CMD_DRAIN, $urandom_range(1));
            end
            settle();
        end

        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
